// File: hdl/bvm_pkg.sv
// Shared types, constants and the cell band function of the battery voltage monitor.
package bvm_pkg;

  // Field widths
  localparam int unsigned RAW_W      = 12;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned MV_W       = 16;
  localparam int unsigned CELL_W     = 3;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned CUTOFF_W   = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned SLOTS      = 3;

  // Register reset values
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 24'd586080;
  localparam logic [CUTOFF_W-1:0] CUTOFF_RST = 13'd3500;
  localparam logic                BUZZER_RST = 1'b1;

  // Time windows in ms
  localparam logic [TIME_W-1:0] UPDATE_MS   = 32'd250;
  localparam logic [TIME_W-1:0] SLOT0_MS    = 32'd1000;
  localparam logic [TIME_W-1:0] SLOT1_MS    = 32'd2000;
  localparam logic [TIME_W-1:0] SLOT2_MS    = 32'd3000;
  localparam logic [TIME_W-1:0] CLASSIFY_MS = 32'd1000;

  // Voltage levels in mV
  localparam logic [MV_W-1:0] DEAD_FLOOR_MV = 16'd2000;
  localparam logic [MV_W-1:0] BAND_6S_HI    = 16'd25800;
  localparam logic [MV_W-1:0] BAND_6S_LO    = 16'd21500;
  localparam logic [MV_W-1:0] BAND_5S_LO    = 16'd17500;
  localparam logic [MV_W-1:0] BAND_4S_LO    = 16'd13500;
  localparam logic [MV_W-1:0] BAND_3S_LO    = 16'd8600;
  localparam logic [MV_W-1:0] BAND_2S_LO    = 16'd4500;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE  = 2'd0,
    CFG_CUTOFF = 2'd1,
    CFG_BUZZER = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [SCALE_W-1:0]  scale;
    logic [CUTOFF_W-1:0] cutoff;
    logic                buzzer;
  } cfg_t;

  // Scaled item between the multiply stage and the state update
  typedef struct packed {
    logic [MV_W-1:0]   mv;
    logic [TIME_W-1:0] now;
    logic              armed;
  } scaled_t;

  typedef struct packed {
    logic [MV_W-1:0]   mv;
    logic [TIME_W-1:0] ms;
  } slot_t;

  typedef struct packed {
    logic [MV_W-1:0]   voltage;
    logic [MV_W-1:0]   filtered;
    logic [CELL_W-1:0] cells;
    logic [MV_W-1:0]   low_limit;
    logic              dead;
  } res_t;

  // Cell count from voltage bands; a value on an edge or above the top gives 0
  function automatic logic [CELL_W-1:0] classify(input logic [MV_W-1:0] f);
    logic [CELL_W-1:0] c;
    if (f > BAND_6S_LO && f < BAND_6S_HI) c = 3'd6;
    else if (f > BAND_5S_LO && f < BAND_6S_LO) c = 3'd5;
    else if (f > BAND_4S_LO && f < BAND_5S_LO) c = 3'd4;
    else if (f > BAND_3S_LO && f < BAND_4S_LO) c = 3'd3;
    else if (f > BAND_2S_LO && f < BAND_3S_LO) c = 3'd2;
    else if (f < BAND_2S_LO) c = 3'd1;
    else c = 3'd0;
    return c;
  endfunction

endpackage

// File: hdl/bvm_scale.sv
// ADC sample to millivolt scaling with saturation.
module bvm_scale (
  input  logic [bvm_pkg::RAW_W-1:0]   raw_i,
  input  logic [bvm_pkg::SCALE_W-1:0] scale_i,
  output logic [bvm_pkg::MV_W-1:0]    mv_o
);

  localparam int unsigned PROD_W = bvm_pkg::RAW_W + bvm_pkg::SCALE_W;

  logic [PROD_W-1:0] prod;

  // Q16 product, fraction dropped, clamp to 16 bits
  always_comb begin
    prod = PROD_W'(raw_i) * PROD_W'(scale_i);
    if (|prod[PROD_W-1:16+bvm_pkg::MV_W]) mv_o = '1;
    else mv_o = prod[16+bvm_pkg::MV_W-1:16];
  end

endmodule

// File: hdl/bvm_peak.sv
// Three-slot peak hold with aging on 1, 2 and 3 second windows.
module bvm_peak (
  input  logic [bvm_pkg::MV_W-1:0]   mv_i,
  input  logic [bvm_pkg::TIME_W-1:0] now_i,
  input  bvm_pkg::slot_t             slots_i [bvm_pkg::SLOTS],
  output bvm_pkg::slot_t             slots_o [bvm_pkg::SLOTS]
);

  bvm_pkg::slot_t            held [bvm_pkg::SLOTS];
  logic [bvm_pkg::TIME_W-1:0] age2, age1, age0;

  always_comb begin
    // capture a new peak in each slot independently
    for (int k = 0; k < bvm_pkg::SLOTS; k++) begin
      held[k] = slots_i[k];
      if (mv_i > slots_i[k].mv) begin
        held[k].mv = mv_i;
        held[k].ms = now_i;
      end
    end

    // modular age of each slot
    age2 = now_i - held[2].ms;
    age1 = now_i - held[1].ms;
    age0 = now_i - held[0].ms;

    // expired slots take the next younger one; slot 0 restarts on the sample
    slots_o[2] = (age2 > bvm_pkg::SLOT2_MS) ? held[1] : held[2];
    slots_o[1] = (age1 > bvm_pkg::SLOT1_MS) ? held[0] : held[1];
    slots_o[0] = held[0];
    if (age0 > bvm_pkg::SLOT0_MS) begin
      slots_o[0].mv = mv_i;
      slots_o[0].ms = now_i;
    end
  end

endmodule

// File: hdl/bvm_core.sv
// Filter state, cell classification, low limit and the result register.
module bvm_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  bvm_pkg::scaled_t item_i,
  input  bvm_pkg::cfg_t    cfg_i,
  output bvm_pkg::res_t    res_o
);

  logic [bvm_pkg::MV_W-1:0]   last_v_q, last_v_d;
  logic [bvm_pkg::MV_W-1:0]   filt_q, filt_d;
  logic [bvm_pkg::TIME_W-1:0] upd_q, upd_d;
  logic [bvm_pkg::CELL_W-1:0] cells_q, cells_d;
  logic [bvm_pkg::MV_W-1:0]   lim_q, lim_d;
  bvm_pkg::slot_t             slots_q [bvm_pkg::SLOTS];
  bvm_pkg::slot_t             slots_d [bvm_pkg::SLOTS];
  bvm_pkg::slot_t             peak_slots [bvm_pkg::SLOTS];
  bvm_pkg::res_t              res_q, res_d;
  logic [bvm_pkg::TIME_W-1:0] since_upd;

  bvm_peak u_peak (
    .mv_i    (item_i.mv),
    .now_i   (item_i.now),
    .slots_i (slots_q),
    .slots_o (peak_slots)
  );

  // next state for one item
  always_comb begin
    last_v_d  = item_i.mv;
    filt_d    = filt_q;
    upd_d     = upd_q;
    slots_d   = slots_q;
    cells_d   = cells_q;
    lim_d     = lim_q;
    since_upd = item_i.now - upd_q;

    if (last_v_q == '0) begin
      filt_d = item_i.mv;
    end else if (since_upd > bvm_pkg::UPDATE_MS) begin
      upd_d   = item_i.now;
      slots_d = peak_slots;
      filt_d  = peak_slots[2].mv;
    end

    // one-shot classification; 8191 * 7 fits in 16 bits, no clamp needed
    if (item_i.now > bvm_pkg::CLASSIFY_MS && cells_q == '0) begin
      cells_d = bvm_pkg::classify(filt_d);
      lim_d   = bvm_pkg::MV_W'(cfg_i.cutoff) * bvm_pkg::MV_W'(cells_d);
    end

    res_d.voltage   = item_i.mv;
    res_d.filtered  = filt_d;
    res_d.cells     = cells_d;
    res_d.low_limit = lim_d;
    res_d.dead      = (filt_d < lim_d) && item_i.armed &&
                      (filt_d > bvm_pkg::DEAD_FLOOR_MV) && cfg_i.buzzer;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_v_q <= '0;
      filt_q   <= '0;
      upd_q    <= '0;
      cells_q  <= '0;
      lim_q    <= '0;
      for (int k = 0; k < bvm_pkg::SLOTS; k++) begin
        slots_q[k] <= '0;
      end
    end else if (step_i) begin
      last_v_q <= last_v_d;
      filt_q   <= filt_d;
      upd_q    <= upd_d;
      cells_q  <= cells_d;
      lim_q    <= lim_d;
      slots_q  <= slots_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  // a known cell count is never lost
  a_cells_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cells_q != '0 |=> cells_q != '0)
    else $error("cell count cleared after classification");

  // the low limit moves only on a classification attempt
  a_lim_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(lim_q) |-> $past(step_i) && $past(cells_q) == '0)
    else $error("low limit changed outside classification");

  // the update stamp moves only on a peak-hold update
  a_upd_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(upd_q) |-> $past(step_i) && $past(last_v_q) != '0)
    else $error("update time changed without a peak-hold update");

endmodule

// File: hdl/battery_voltage_monitor.sv
// Top level of the battery voltage monitor: registers, pipeline and handshakes.
//
// Channel   Direction  Handshake                Payload
// in        sink       in_valid_i / in_stall_o  raw_sample_i, now_ms_i, armed_i
// out       source     out_valid_o / out_stall_i voltage_mv_o, filtered_mv_o, cells_o,
//                                               low_limit_mv_o, dead_battery_o
// cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle while out is not stalled; each item passes the input
// register, the multiply stage and the state update into the result register.
// The state update is a single pass per item, so back-to-back items see the
// state left by the one before.
// Reset clears valid flags and core state, loads register defaults; no sweep is needed.
// A stall on out fills the empty stages first; in stalls only once all three hold items.
module battery_voltage_monitor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [bvm_pkg::RAW_W-1:0]        raw_sample_i,
  input  logic [bvm_pkg::TIME_W-1:0]       now_ms_i,
  input  logic                             armed_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [bvm_pkg::MV_W-1:0]         voltage_mv_o,
  output logic [bvm_pkg::MV_W-1:0]         filtered_mv_o,
  output logic [bvm_pkg::CELL_W-1:0]       cells_o,
  output logic [bvm_pkg::MV_W-1:0]         low_limit_mv_o,
  output logic                             dead_battery_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bvm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bvm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  bvm_pkg::cfg_t    cfg_q;
  logic             s1_valid_q, s2_valid_q, out_valid_q;
  logic             en1, en2, en3;
  logic [bvm_pkg::RAW_W-1:0]  s1_raw_q;
  logic [bvm_pkg::TIME_W-1:0] s1_now_q;
  logic             s1_armed_q;
  logic [bvm_pkg::MV_W-1:0]   scaled_mv;
  bvm_pkg::scaled_t s2_q, s2_d;
  bvm_pkg::res_t    res;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale  <= bvm_pkg::SCALE_RST;
      cfg_q.cutoff <= bvm_pkg::CUTOFF_RST;
      cfg_q.buzzer <= bvm_pkg::BUZZER_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bvm_pkg::cfg_idx_e'(cfg_index_i))
        bvm_pkg::CFG_SCALE:  cfg_q.scale  <= cfg_data_i[bvm_pkg::SCALE_W-1:0];
        bvm_pkg::CFG_CUTOFF: cfg_q.cutoff <= cfg_data_i[bvm_pkg::CUTOFF_W-1:0];
        bvm_pkg::CFG_BUZZER: cfg_q.buzzer <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage moves when it is empty or the next one moves
  assign en3        = !out_valid_q || !out_stall_i;
  assign en2        = !s2_valid_q || en3;
  assign en1        = !s1_valid_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) s1_valid_q  <= in_valid_i;
      if (en2) s2_valid_q  <= s1_valid_q;
      if (en3) out_valid_q <= s2_valid_q;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_raw_q   <= raw_sample_i;
      s1_now_q   <= now_ms_i;
      s1_armed_q <= armed_i;
    end
  end

  bvm_scale u_scale (
    .raw_i   (s1_raw_q),
    .scale_i (cfg_q.scale),
    .mv_o    (scaled_mv)
  );

  // scaled item register
  always_comb begin
    s2_d.mv    = scaled_mv;
    s2_d.now   = s1_now_q;
    s2_d.armed = s1_armed_q;
  end

  always_ff @(posedge clk_i) begin
    if (en2 && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  bvm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (en3 && s2_valid_q),
    .item_i (s2_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_valid_o    = out_valid_q;
  assign voltage_mv_o   = res.voltage;
  assign filtered_mv_o  = res.filtered;
  assign cells_o        = res.cells;
  assign low_limit_mv_o = res.low_limit;
  assign dead_battery_o = res.dead;

  // input is held off only when the whole pipeline is full and blocked
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && s1_valid_q && s2_valid_q)
    else $error("input stalled while the pipeline had room");

endmodule
